// ----- hw/rtl/r2fft_pkg.sv -----
// shared types, constants and twiddle table for the radix-2 transform
package r2fft_pkg;

	localparam int SampleW = 16;
	localparam int DataW   = 24;
	localparam int TwW     = 17;
	localparam int MaxLog  = 6;

	typedef struct packed {
		logic [SampleW-1:0] value;
		logic               last;
	} sample_t;

	// round(32768*cos(2*pi*k/64)) for k = 0..16
	function automatic logic signed [TwW-1:0] quarter_cos(input logic [4:0] k);
		logic signed [TwW-1:0] r;
		case (k)
			5'd0:  r = 17'sd32768;
			5'd1:  r = 17'sd32610;
			5'd2:  r = 17'sd32138;
			5'd3:  r = 17'sd31357;
			5'd4:  r = 17'sd30274;
			5'd5:  r = 17'sd28899;
			5'd6:  r = 17'sd27246;
			5'd7:  r = 17'sd25330;
			5'd8:  r = 17'sd23170;
			5'd9:  r = 17'sd20788;
			5'd10: r = 17'sd18205;
			5'd11: r = 17'sd15447;
			5'd12: r = 17'sd12540;
			5'd13: r = 17'sd9512;
			5'd14: r = 17'sd6393;
			5'd15: r = 17'sd3212;
			default: r = 17'sd0;
		endcase
		return r;
	endfunction

	// exp(+j*2*pi*k/64): real part in [2*TwW-1:TwW], imaginary part below
	function automatic logic [2*TwW-1:0] twiddle(input logic [5:0] k);
		logic [4:0] m;
		logic [4:0] mc;
		logic signed [TwW-1:0] wr;
		logic signed [TwW-1:0] wi;
		m  = {1'b0, k[3:0]};
		mc = 5'd16 - m;
		case (k[5:4])
			2'd0: begin wr = quarter_cos(m); wi = quarter_cos(mc); end
			2'd1: begin wr = -quarter_cos(mc); wi = quarter_cos(m); end
			2'd2: begin wr = -quarter_cos(m); wi = -quarter_cos(mc); end
			default: begin wr = quarter_cos(mc); wi = -quarter_cos(m); end
		endcase
		return {wr, wi};
	endfunction

endpackage

// ----- hw/rtl/r2fft_fifo.sv -----
// short queue between sample intake and the transform engine
module r2fft_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               flush,
	input  logic               push,
	input  r2fft_pkg::sample_t push_data,
	output logic               full,
	input  logic               pop,
	output logic               empty,
	output r2fft_pkg::sample_t pop_data
);
	r2fft_pkg::sample_t mem_q [4];
	logic [2:0] wr_q, rd_q;

	assign full     = (wr_q[1:0] == rd_q[1:0]) && (wr_q[2] != rd_q[2]);
	assign empty    = wr_q == rd_q;
	assign pop_data = mem_q[rd_q[1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
		end else if (flush) begin
			wr_q <= '0;
			rd_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 3'd1;
			if (pop) rd_q <= rd_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q[1:0]] <= push_data;
	end
endmodule

// ----- hw/rtl/r2fft_engine.sv -----
// store, butterfly sequencer and bin output
module r2fft_engine (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [2:0]                      lg,
	input  logic                            flush,
	input  logic                            q_empty,
	input  r2fft_pkg::sample_t              q_data,
	output logic                            q_pop,
	output logic signed [r2fft_pkg::DataW-1:0] bin_real,
	output logic signed [r2fft_pkg::DataW-1:0] bin_imag,
	output logic                            last_bin,
	output logic                            valid,
	input  logic                            stall
);
	localparam int DW = r2fft_pkg::DataW;
	localparam int TW = r2fft_pkg::TwW;

	typedef enum logic [3:0] {
		LOAD, PAD, BF_RDA, BF_RDB, BF_MUL, BF_ADD, BF_WRA, BF_WRB, OUT_RD, OUT_WAIT, OUT_HOLD
	} state_t;

	state_t state_q;
	logic [2*DW-1:0] mem [64];
	logic [6:0] cnt_q;
	logic [2:0] stage_q;
	logic [5:0] bf_q;
	logic [5:0] rd_addr;
	logic [2*DW-1:0] rd_data_q;
	logic we;
	logic [5:0] wr_addr;
	logic [2*DW-1:0] wr_data;
	logic signed [DW-1:0] ar_q, ai_q, sr_q, si_q, dr_q, di_q;
	logic signed [TW+DW:0] pr_q, pi_q;
	logic signed [TW-1:0] wr_w, wi_w;
	logic [6:0] npts;
	logic [5:0] pa, pb, kidx, half, nmask;
	logic [5:0] ibr;
	logic signed [TW+DW:0] rr, ri;

	assign npts  = 7'd1 << lg;
	assign nmask = 6'(npts - 7'd1);
	assign half  = 6'(7'd1 << stage_q);
	// butterfly index bf: group above stage bit, offset below
	assign pa    = ((bf_q >> stage_q) << (stage_q + 3'd1)) | (bf_q & (half - 6'd1));
	assign pb    = pa | half;
	assign kidx  = 6'((bf_q & (half - 6'd1)) << (3'd5 - stage_q));
	assign {wr_w, wi_w} = r2fft_pkg::twiddle(kidx);

	// bit reversal of the load position over lg bits
	always_comb begin
		logic [5:0] r;
		r = '0;
		for (int i = 0; i < 6; i++) r[5-i] = cnt_q[i];
		ibr = (lg == 3'd0) ? 6'd0 : 6'(r >> (3'd6 - lg));
	end

	assign q_pop = (state_q == LOAD) && !q_empty && !flush;

	always_comb begin
		rd_addr = 6'(cnt_q);
		if (state_q == BF_RDA) rd_addr = pa;
		if (state_q == BF_RDB) rd_addr = pb;
	end

	// rounding, half up: floor((s + 2^14) / 2^15)
	assign rr = (pr_q + (TW+DW+1)'(16384)) >>> 15;
	assign ri = (pi_q + (TW+DW+1)'(16384)) >>> 15;

	always_comb begin
		we = 1'b0;
		wr_addr = ibr;
		wr_data = '0;
		case (state_q)
			LOAD: begin
				we = q_pop;
				wr_data = {DW'(signed'(q_data.value)), {DW{1'b0}}};
			end
			PAD: we = (cnt_q < npts);
			BF_WRA: begin we = 1'b1; wr_addr = pa; wr_data = {sr_q, si_q}; end
			BF_WRB: begin we = 1'b1; wr_addr = pb; wr_data = {dr_q, di_q}; end
			default: we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) mem[wr_addr] <= wr_data;
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= LOAD;
			cnt_q    <= '0;
			stage_q  <= '0;
			bf_q     <= '0;
			valid    <= 1'b0;
			last_bin <= 1'b0;
		end else if (flush) begin
			state_q <= LOAD;
			cnt_q   <= '0;
			valid   <= 1'b0;
		end else begin
			case (state_q)
				LOAD: if (q_pop) begin
					cnt_q <= cnt_q + 7'd1;
					if (q_data.last || (cnt_q + 7'd1) >= npts)
						state_q <= PAD;
				end
				PAD: begin
					// zero fill: writing at bit-reversed cnt for the tail entries
					if (cnt_q >= npts) begin
						stage_q <= '0;
						bf_q    <= '0;
						cnt_q   <= '0;
						state_q <= (lg == 3'd0) ? OUT_RD : BF_RDA;
					end else cnt_q <= cnt_q + 7'd1;
				end
				BF_RDA: state_q <= BF_RDB;
				BF_RDB: begin
					{ar_q, ai_q} <= rd_data_q;
					state_q <= BF_MUL;
				end
				BF_MUL: begin
					pr_q <= wr_w * signed'(rd_data_q[2*DW-1:DW]) - wi_w * signed'(rd_data_q[DW-1:0]);
					pi_q <= wr_w * signed'(rd_data_q[DW-1:0]) + wi_w * signed'(rd_data_q[2*DW-1:DW]);
					state_q <= BF_ADD;
				end
				BF_ADD: begin
					sr_q <= ar_q + DW'(rr);
					si_q <= ai_q + DW'(ri);
					dr_q <= ar_q - DW'(rr);
					di_q <= ai_q - DW'(ri);
					state_q <= BF_WRA;
				end
				BF_WRA: state_q <= BF_WRB;
				BF_WRB: begin
					if (bf_q == (nmask >> 1)) begin
						bf_q <= '0;
						if (stage_q + 3'd1 == lg) begin
							cnt_q <= '0;
							state_q <= OUT_RD;
						end else begin
							stage_q <= stage_q + 3'd1;
							state_q <= BF_RDA;
						end
					end else begin
						bf_q <= bf_q + 6'd1;
						state_q <= BF_RDA;
					end
				end
				OUT_RD: state_q <= OUT_WAIT;
				OUT_WAIT: begin
					{bin_real, bin_imag} <= rd_data_q;
					last_bin <= (cnt_q + 7'd1) == npts;
					valid    <= 1'b1;
					state_q  <= OUT_HOLD;
				end
				OUT_HOLD: if (!stall) begin
					valid <= 1'b0;
					if ((cnt_q + 7'd1) == npts) begin
						cnt_q <= '0;
						state_q <= LOAD;
					end else begin
						cnt_q <= cnt_q + 7'd1;
						state_q <= OUT_RD;
					end
				end
				default: state_q <= LOAD;
			endcase
		end
	end
endmodule

// ----- hw/rtl/radix2_fft.sv -----
// top level of the block radix-2 decimation-in-time transform
//
// channel    signals                                   direction
// samples    valid_in/stall_in, sample_value, last_sample  in
// bins       valid/stall, bin_real, bin_imag, last_bin       out
// config     cfg_valid/cfg_ready, cfg_data                   in
//
// samples enter a four-deep queue at one per cycle while it is not full, and are loaded
// into the store in bit-reversed order; the single butterfly unit steps each butterfly
// through read a, read b, multiply, add, write a and write b, (N/2)*log2(N) butterflies,
// then each bin is read, registered and held until the output is not stalled
// a config write flushes the queue and any partial block
// reset: arst_n clears control state; store contents beyond loaded entries are zero padded
module radix2_fft (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               valid_in,
	output logic                               stall_in,
	input  logic signed [15:0]                 sample_value,
	input  logic                               last_sample,
	output logic                               valid,
	input  logic                               stall,
	output logic signed [23:0]                 bin_real,
	output logic signed [23:0]                 bin_imag,
	output logic                               last_bin,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [2:0]                         cfg_data
);
	logic [2:0] lg_q;
	logic       full, empty, pop, wr_cfg;
	r2fft_pkg::sample_t pushd, popd;

	assign cfg_ready = 1'b1;
	assign wr_cfg    = cfg_valid;
	assign stall_in  = full;
	assign pushd     = '{value: sample_value, last: last_sample};

	// clamp out-of-range point counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) lg_q <= 3'(r2fft_pkg::MaxLog);
		else if (wr_cfg)
			lg_q <= (cfg_data > 3'(r2fft_pkg::MaxLog)) ? 3'(r2fft_pkg::MaxLog) : cfg_data;
	end

	r2fft_fifo u_fifo (
		.clk, .arst_n, .flush(wr_cfg),
		.push(valid_in && !full), .push_data(pushd), .full,
		.pop, .empty, .pop_data(popd)
	);

	r2fft_engine u_engine (
		.clk, .arst_n, .lg(lg_q), .flush(wr_cfg),
		.q_empty(empty), .q_data(popd), .q_pop(pop),
		.bin_real, .bin_imag, .last_bin, .valid, .stall
	);
endmodule

// ----- hw/rtl/radix2_fft_checker.sv -----
// port-level checks for the transform block
module radix2_fft_checker (
	input logic clk,
	input logic arst_n,
	input logic valid,
	input logic stall,
	input logic last_bin,
	input logic [23:0] bin_real
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && stall |=> valid && $stable(bin_real)) else $error("bin dropped under stall");
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid && stall |=> $stable(last_bin)) else $error("last flag");
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !stall |=> !valid) else $error("bin repeated");
	a_rst: assert property (@(posedge clk)
		!arst_n |-> !valid) else $error("bin during reset");
endmodule

bind radix2_fft radix2_fft_checker u_chk (.clk, .arst_n, .valid, .stall, .last_bin, .bin_real);
